>>> rtl/core/b64sd_pkg.sv
// shared types, constants and the character map of the base64url decoder
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam int MaxResults = 3;
    localparam int QueueDepth = 8;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);
    localparam int CntW       = $clog2(MaxResults + 1);

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_end;
        logic       message_end;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]             num;
        t_result [MaxResults-1:0]    res;
    } t_group;

    // returns {miss, sextet}; miss is set for bytes outside the alphabet
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [7:0] d;
        logic       miss;
        d    = 8'd0;
        miss = 1'b0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h47;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'h04;
        end else if (c == 8'h2D) begin
            d = 8'd62;
        end else if (c == 8'h5F) begin
            d = 8'd63;
        end else begin
            miss = 1'b1;
        end
        return {miss, d[5:0]};
    endfunction

endpackage

>>> rtl/core/b64sd_if.sv
// valid/ready channel interfaces for the character input and the byte output
`timescale 1ns / 1ps

interface b64sd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_message;

    modport source (output valid, output in_char, output end_of_message, input ready);
    modport sink   (input valid, input in_char, input end_of_message, output ready);
endinterface

interface b64sd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       message_end;

    modport source (output valid, output out_byte, output byte_valid, output run_end,
                    output message_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_end,
                    input message_end, output ready);
endinterface

>>> rtl/core/base64url_stream_decoder_unit.sv
// top level of the base64url stream decoder
`timescale 1ns / 1ps
//
// usage
// - i_in carries one character word per handshake: the raw byte and an
//   end-of-message flag; bytes outside the url-safe alphabet, padding included,
//   are dropped, but a flagged one still closes the message
// - o_out carries one result word per handshake: a decoded byte with
//   byte_valid set, or a bare end marker with byte_valid clear
// - run_end marks the last result caused by one character, message_end the
//   last result of the message
// - a taken character is held in the input register until the queue has room
//   for a whole group; its results are then written into the result queue,
//   from which the first of them shows on o_out
// - throughput is one character per cycle while the queue has room, and one
//   output byte per cycle while not stalled; four characters give three bytes
// - the input stalls only while the eight-entry queue has fewer than three
//   free slots, which a stalled receiver causes
// - reset empties the queue and the input register and clears the gathered
//   sextets; o_out.valid is low after reset
//
module base64url_stream_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    b64sd_in_if.sink           i_in,
    b64sd_out_if.source        o_out
);
    import b64sd_pkg::*;

    t_in_word in_word;
    t_in_word dec_word;
    t_group   group;
    t_result  res;
    logic     fire;
    logic     room;
    logic     in_ready;
    logic     out_valid;

    // pack the input channel payload
    assign in_word.in_char        = i_in.in_char;
    assign in_word.end_of_message = i_in.end_of_message;
    assign i_in.ready             = in_ready;

    // input register, advances when the queue has room for a whole group
    b64sd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_word  (in_word),
        .i_room  (room),
        .o_fire  (fire),
        .o_word  (dec_word)
    );

    // sextet gathering and byte forming
    b64sd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (dec_word),
        .o_group (group)
    );

    // result register file and output serializer
    b64sd_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_group  (group),
        .o_room   (room),
        .o_valid  (out_valid),
        .i_ready  (o_out.ready),
        .o_result (res)
    );

    // unpack the output word
    assign o_out.valid       = out_valid;
    assign o_out.out_byte    = res.out_byte;
    assign o_out.byte_valid  = res.byte_valid;
    assign o_out.run_end     = res.run_end;
    assign o_out.message_end = res.message_end;

endmodule

>>> rtl/core/b64sd_in_reg.sv
// input register that holds one character word until the decoder takes it
`timescale 1ns / 1ps

module b64sd_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64sd_pkg::t_in_word i_word,
    input  logic                i_room,
    output logic                o_fire,
    output b64sd_pkg::t_in_word o_word
);
    import b64sd_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_fire  = r_valid && i_room;
    assign o_ready = !r_valid || i_room;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

>>> rtl/core/b64sd_decode.sv
// sextet gathering state and the logic that forms the result group of one word
`timescale 1ns / 1ps

module b64sd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  b64sd_pkg::t_in_word i_word,
    output b64sd_pkg::t_group   o_group
);
    import b64sd_pkg::*;

    logic [1:0]  r_sc;
    logic [17:0] r_hs;
    logic [1:0]  n_sc;
    logic [17:0] n_hs;
    logic [6:0]  map;
    logic [5:0]  v;
    t_group      g;

    function automatic t_result data_res(input logic [7:0] b);
        t_result r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    always_comb begin
        map  = map_char(i_word.in_char);
        v    = map[5:0];
        g    = '0;
        n_sc = r_sc;
        n_hs = r_hs;

        if (!map[6]) begin
            if (r_sc == 2'd3) begin
                g.res[0] = data_res({r_hs[17:12], r_hs[11:10]});
                g.res[1] = data_res({r_hs[9:6], r_hs[5:2]});
                g.res[2] = data_res({r_hs[1:0], v});
                g.num    = CntW'(3);
                n_sc     = 2'd0;
                n_hs     = 18'd0;
            end else begin
                n_hs = {r_hs[11:0], v};
                n_sc = r_sc + 2'd1;
            end
        end

        if (i_word.end_of_message) begin
            if (n_sc == 2'd3) begin
                g.res[0] = data_res({n_hs[17:12], n_hs[11:10]});
                g.res[1] = data_res({n_hs[9:6], n_hs[5:2]});
                g.num    = CntW'(2);
            end else if (n_sc == 2'd2) begin
                g.res[0] = data_res({n_hs[11:6], n_hs[5:4]});
                g.num    = CntW'(1);
            end
            // nothing released: a bare end marker
            if (g.num == '0) begin
                g.res[0] = '0;
                g.num    = CntW'(1);
            end
            g.res[g.num - CntW'(1)].message_end = 1'b1;
            n_sc = 2'd0;
            n_hs = 18'd0;
        end

        if (g.num != '0) begin
            g.res[g.num - CntW'(1)].run_end = 1'b1;
        end
    end

    assign o_group = g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= 2'd0;
            r_hs <= 18'd0;
        end else if (i_fire) begin
            r_sc <= n_sc;
            r_hs <= n_hs;
        end
    end

endmodule

>>> rtl/core/b64sd_res_queue.sv
// result queue that takes up to three results a cycle and hands out one
`timescale 1ns / 1ps

module b64sd_res_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64sd_pkg::t_group  i_group,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output b64sd_pkg::t_result o_result
);
    import b64sd_pkg::*;

    t_result          r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QCntW-1:0] r_cnt;
    logic [QCntW-1:0] push_n;
    logic             pop;

    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;
    assign push_n   = i_push ? QCntW'(i_group.num) : '0;
    // room for a full group before it is formed
    assign o_room   = (r_cnt <= QCntW'(QueueDepth - MaxResults));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPtrW'(push_n);
            r_rd  <= r_rd + QPtrW'(pop);
            r_cnt <= r_cnt + push_n - QCntW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MaxResults; k++) begin
            if (i_push && (k < int'(i_group.num))) begin
                r_mem[r_wr + QPtrW'(k)] <= i_group.res[k];
            end
        end
    end

endmodule

>>> rtl/core/b64sd_checker.sv
// port checks of the base64url stream decoder and their bind
`timescale 1ns / 1ps

module b64sd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_byte_valid,
    input logic i_out_run_end,
    input logic i_out_message_end
);

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a stalled output word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // a bare marker only closes a message
    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_byte_valid |-> i_out_message_end && i_out_run_end)
        else $error("bare marker without end flags");

    // with nothing queued and nothing just taken, the input is open
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && $past(i_rst_n) && !$past(i_in_valid && i_in_ready)
            |-> i_in_ready)
        else $error("input blocked while idle");

endmodule

bind base64url_stream_decoder_unit b64sd_checker u_b64sd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_byte_valid  (o_out.byte_valid),
    .i_out_run_end     (o_out.run_end),
    .i_out_message_end (o_out.message_end)
);

>>> tb/tb_base64url_stream_decoder_unit.sv
// testbench for the base64url stream decoder: directed and random messages against a predictor
`timescale 1ns / 1ps

module tb_base64url_stream_decoder_unit;

    import b64sd_pkg::*;

    localparam int    IdleLimit  = 2000;
    localparam int    DrainWait  = 12;
    localparam string UrlSafeSet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    logic i_clk;
    logic i_rst_n;

    b64sd_in_if  in_ch ();
    b64sd_out_if out_ch ();

    base64url_stream_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state: gathered sextets, oldest in the high bits
    logic [1:0]  sextet_cnt;
    logic [17:0] held_sextets;

    t_result decoded_bytes[$];
    int      mismatches = 0;
    int      sent_items;
    int      idle_cycles = 0;
    int      stall_left = 0;
    bit      gaps_on;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // sextet value of a character, -1 when it is outside the url-safe set
    function automatic int lookup_sextet(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (UrlSafeSet[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic t_result data_word(input logic [7:0] b);
        t_result r;
        r.out_byte    = b;
        r.byte_valid  = 1'b1;
        r.run_end     = 1'b0;
        r.message_end = 1'b0;
        return r;
    endfunction

    // works out the words one character causes and queues them
    task automatic decode_char(input logic [7:0] c, input logic eom);
        t_result    words[$];
        t_result    bare;
        int         v;
        logic [5:0] s0, s1, s2, sv;
        v  = lookup_sextet(c);
        sv = v[5:0];
        if (v >= 0) begin
            if (sextet_cnt == 2'd3) begin
                s0 = held_sextets[17:12];
                s1 = held_sextets[11:6];
                s2 = held_sextets[5:0];
                words = {words, data_word({s0, s1[5:4]})};
                words = {words, data_word({s1[3:0], s2[5:2]})};
                words = {words, data_word({s2[1:0], sv})};
                sextet_cnt   = 2'd0;
                held_sextets = 18'd0;
            end else begin
                held_sextets = {held_sextets[11:0], sv};
                sextet_cnt   = sextet_cnt + 2'd1;
            end
        end
        if (eom) begin
            if (sextet_cnt == 2'd3) begin
                s0 = held_sextets[17:12];
                s1 = held_sextets[11:6];
                s2 = held_sextets[5:0];
                words = {words, data_word({s0, s1[5:4]})};
                words = {words, data_word({s1[3:0], s2[5:2]})};
            end else if (sextet_cnt == 2'd2) begin
                s0 = held_sextets[11:6];
                s1 = held_sextets[5:0];
                words = {words, data_word({s0, s1[5:4]})};
            end
            // nothing released at the end: a bare end marker instead
            if (words.size() == 0) begin
                bare  = '0;
                words = {words, bare};
            end
            sextet_cnt   = 2'd0;
            held_sextets = 18'd0;
            words[words.size()-1].message_end = 1'b1;
        end
        if (words.size() > 0) words[words.size()-1].run_end = 1'b1;
        foreach (words[i]) decoded_bytes = {decoded_bytes, words[i]};
    endtask

    // drives one character word and waits for the handshake
    task automatic send_char(input logic [7:0] c, input logic eom);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.in_char        <= c;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_char(c, eom);
        sent_items++;
    endtask

    function automatic logic [7:0] any_url_char();
        return UrlSafeSet[$urandom_range(0, 63)];
    endfunction

    // mostly well-formed text with some stray bytes, closed by a flagged character
    task automatic send_random_message();
        int len;
        len = $urandom_range(0, 13);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
            send_char(any_url_char(), 1'b0);
        end
        if ($urandom_range(0, 4) == 0) send_char(8'($urandom_range(0, 255)), 1'b1);
        else                           send_char(any_url_char(), 1'b1);
    endtask

    task automatic test_edge_characters();
        // stray bytes at both ends of the range, each closing a message
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        // lone leftover sextet at the end
        send_char(8'h41, 1'b1);                           // A
        // full group on the final character, all ones
        send_char(8'h5F, 1'b0);                           // _
        send_char(8'h5F, 1'b0);
        send_char(8'h5F, 1'b0);
        send_char(8'h5F, 1'b1);
        // two sextets and padding, the end flag on a pad
        send_char(8'h41, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h3D, 1'b0);                           // =
        send_char(8'h3D, 1'b1);
        // three sextets at the end
        send_char(8'h7A, 1'b0);                           // z
        send_char(8'h39, 1'b0);                           // 9
        send_char(8'h2D, 1'b1);                           // -
        // group with neighbors of every range boundary in between
        send_char(8'h5A, 1'b0);                           // Z
        send_char(8'h61, 1'b0);                           // a
        send_char(8'h30, 1'b0);                           // 0
        send_char(8'h40, 1'b0);                           // @
        send_char(8'h5B, 1'b0);                           // [
        send_char(8'h60, 1'b0);                           // `
        send_char(8'h7B, 1'b0);                           // {
        send_char(8'h2F, 1'b0);                           // /
        send_char(8'h3A, 1'b0);                           // :
        send_char(8'h5F, 1'b0);
        // empty remainder, stray final byte: bare marker
        send_char(8'h80, 1'b1);
    endtask

    task automatic test_random_with_gaps(input int target);
        gaps_on = 1'b1;
        while (sent_items < target) send_random_message();
    endtask

    task automatic test_full_rate(input int target);
        gaps_on = 1'b0;
        while (sent_items < target) send_random_message();
    endtask

    // receiver: random stall bursts while gaps are on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            stall_left   <= $urandom_range(0, 5);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // compares each result word with the oldest predicted one
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (decoded_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual byte=%h valid=%b %s",
                         $time, out_ch.out_byte, out_ch.byte_valid,
                         $sformatf("run_end=%b msg_end=%b", out_ch.run_end,
                                   out_ch.message_end));
            end else begin
                want = decoded_bytes.pop_front();
                if (out_ch.out_byte !== want.out_byte ||
                    out_ch.byte_valid !== want.byte_valid ||
                    out_ch.run_end !== want.run_end ||
                    out_ch.message_end !== want.message_end) begin
                    mismatches++;
                    $display("%0t: expected byte=%h valid=%b run_end=%b msg_end=%b,",
                             $time, want.out_byte, want.byte_valid, want.run_end,
                             want.message_end);
                    $display("%0t: actual byte=%h valid=%b run_end=%b msg_end=%b",
                             $time, out_ch.out_byte, out_ch.byte_valid, out_ch.run_end,
                             out_ch.message_end);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("base64url_stream_decoder_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.in_char        <= 8'h00;
        in_ch.end_of_message <= 1'b0;
        sextet_cnt   = 2'd0;
        held_sextets = 18'd0;
        sent_items   = 0;
        gaps_on      = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_characters();
        test_random_with_gaps(300);
        test_full_rate(480);

        in_ch.valid <= 1'b0;
        while (decoded_bytes.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("base64url_stream_decoder_unit: match");
        end else begin
            $display("base64url_stream_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
